[rtl/core/qoi_pkg.sv]
// ----------------------------------------------------------------------------
// qoi_pkg
// Shared types, op codes and helpers of the QOI stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qoi_pkg;

  localparam logic [31:0] QOI_MAGIC         = 32'h716F_6966;
  localparam logic [31:0] PIXEL_LIMIT_RESET = 32'd400000000;

  localparam logic [7:0] OP_RGB  = 8'hFE;
  localparam logic [7:0] OP_RGBA = 8'hFF;

  // two-bit tags in the top of an op byte
  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HDR_OK = 2'd1;
  localparam logic [1:0] KIND_HDR_BAD = 2'd2;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } qoi_pixel_t;

  localparam qoi_pixel_t OPAQUE_BLACK = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'hFF};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } qoi_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  channel_count;
    logic [7:0]  color_space;
    logic        run_last;
    logic        image_last;
  } qoi_out_t;

  // header parser status toward the pixel sequencer
  typedef struct packed {
    logic        last;
    logic        ok;
    logic [31:0] width;
    logic [31:0] height;
    logic [7:0]  channels;
    logic [7:0]  colorspace;
    logic [31:0] pixel_count;
  } qoi_hdr_t;

  // color table slot: (3r + 5g + 7b + 11a) mod 64
  function automatic logic [5:0] qoi_hash(input qoi_pixel_t p);
    logic [11:0] s;
    s = {4'd0, p.r} * 12'd3 + {4'd0, p.g} * 12'd5 + {4'd0, p.b} * 12'd7
      + {4'd0, p.a} * 12'd11;
    return s[5:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/qoi_color_table.sv]
// ----------------------------------------------------------------------------
// qoi_color_table
// 64-entry color table: one write port, one registered read port, and a
// valid bit per entry so that reset or a new file clears it at once.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_color_table (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                clear,
  input  wire logic                rd_en,
  input  wire logic [5:0]          rd_addr,
  output qoi_pkg::qoi_pixel_t      rd_data,
  input  wire logic                wr_en,
  input  wire logic [5:0]          wr_addr,
  input  qoi_pkg::qoi_pixel_t      wr_data
);

  qoi_pkg::qoi_pixel_t mem [64];
  qoi_pkg::qoi_pixel_t rd_q;
  logic [63:0]         valid;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // an entry never written reads as zero
  assign rd_data = rd_valid ? rd_q : '0;

  a_no_rd_wr_overlap : assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("color table read and write in the same cycle");

  a_no_wr_on_clear : assert property (@(posedge clk) disable iff (rst)
    !(wr_en && clear))
    else $error("color table write during clear");

endmodule

`default_nettype wire

[rtl/core/qoi_hdr_parser.sv]
// ----------------------------------------------------------------------------
// qoi_hdr_parser
// Collects the 14 header bytes, forms width times height a byte ahead of
// the last one and checks the header on the colorspace byte.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_hdr_parser (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         restart,
  input  wire logic         byte_en,
  input  wire logic [7:0]   data_byte,
  input  wire logic [31:0]  pixel_limit,
  output qoi_pkg::qoi_hdr_t hdr
);

  localparam logic [3:0] K_WIDTH      = 4'd4;
  localparam logic [3:0] K_HEIGHT     = 4'd8;
  localparam logic [3:0] K_CHANNELS   = 4'd12;
  localparam logic [3:0] K_COLORSPACE = 4'd13;

  logic [3:0]  header_count;
  logic [3:0]  k;
  logic [31:0] magic_shift;
  logic [31:0] width_shift;
  logic [31:0] height_shift;
  logic [7:0]  channels_seen;
  logic [7:0]  colorspace;
  logic [63:0] area;

  assign k = restart ? 4'd0 : header_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
    end else if (byte_en) begin
      header_count <= k + 4'd1;
    end
  end

  // each field is shifted in whole, so a restart needs no clearing here
  always_ff @(posedge clk) begin
    if (byte_en) begin
      if (k < K_WIDTH) begin
        magic_shift <= {magic_shift[23:0], data_byte};
      end else if (k < K_HEIGHT) begin
        width_shift <= {width_shift[23:0], data_byte};
      end else if (k < K_CHANNELS) begin
        height_shift <= {height_shift[23:0], data_byte};
      end else if (k == K_CHANNELS) begin
        channels_seen <= data_byte;
        area          <= {32'd0, width_shift} * {32'd0, height_shift};
      end else if (k == K_COLORSPACE) begin
        colorspace <= data_byte;
      end
    end
  end

  always_comb begin
    hdr.last        = byte_en && (k == K_COLORSPACE);
    hdr.ok          = (magic_shift == qoi_pkg::QOI_MAGIC) && (width_shift != '0)
                   && (height_shift != '0)
                   && (channels_seen == 8'd3 || channels_seen == 8'd4)
                   && (data_byte <= 8'd1) && (area < {32'd0, pixel_limit});
    hdr.width       = width_shift;
    hdr.height      = height_shift;
    hdr.channels    = channels_seen;
    hdr.colorspace  = colorspace;
    hdr.pixel_count = area[31:0];
  end

endmodule

`default_nettype wire

[rtl/core/qoi_image_stream_decoder.sv]
// ----------------------------------------------------------------------------
// qoi_image_stream_decoder
// QOI decoder: header check, op decode against the previous pixel and a
// 64-entry color table, RGBA pixel output.
// ----------------------------------------------------------------------------
// Bytes enter one per request. Header bytes, op bytes that wait for operands
// and operand bytes other than the last only update state. A byte that
// completes a pixel is followed by the emission of its pixels, one per free
// output slot, and an INDEX byte first by the registered read of the color
// table. The 14th header byte is followed by a state presenting the header
// result. The output register is single: input waits while pixels are
// handed out. Reset and the first byte of a new file clear the color table
// at once, with no clearing pass.
`default_nettype none

module qoi_image_stream_decoder (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  qoi_pkg::qoi_in_t  in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output qoi_pkg::qoi_out_t out_data,
  input  wire logic         cfg_we,
  input  wire logic [31:0]  cfg_data
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_PIXELS = 3'b010,
    PH_IDLE   = 3'b100
  } phase_t;

  typedef enum logic [3:0] {
    S_INPUT  = 4'b0001,
    S_LOOKUP = 4'b0010,
    S_PIXEL  = 4'b0100,
    S_HEADER = 4'b1000
  } state_t;

  state_t              state;
  phase_t              phase;
  phase_t              eff_phase;
  logic [31:0]         pixel_limit;
  logic [7:0]          pending_op;
  logic [2:0]          operand_count;
  qoi_pkg::qoi_pixel_t previous_pixel;
  logic [31:0]         pixels_left;
  logic [5:0]          emit_count;

  logic                accept;
  logic                restart;
  logic                hdr_en;
  logic                pix_en;
  logic                out_free;
  logic                ld_pix;
  logic                ld_hdr;
  logic                run_end;
  logic [7:0]          b;
  logic [7:0]          vg;
  logic [1:0]          k;
  logic [7:0]          pending_op_next;
  logic [2:0]          operand_count_next;
  qoi_pkg::qoi_pixel_t pixel_next;
  logic [5:0]          emit_n;
  logic                go_lookup;

  qoi_pkg::qoi_hdr_t   hdr;
  qoi_pkg::qoi_pixel_t tbl_rd_data;

  assign in_ready  = (state == S_INPUT);
  assign accept    = in_valid && in_ready;
  assign restart   = accept && in_data.file_start;
  assign eff_phase = in_data.file_start ? PH_HEADER : phase;
  assign hdr_en    = accept && (eff_phase == PH_HEADER);
  assign pix_en    = accept && (eff_phase == PH_PIXELS);
  assign out_free  = !out_valid || out_ready;
  assign ld_pix    = (state == S_PIXEL) && out_free;
  assign ld_hdr    = (state == S_HEADER) && out_free;
  assign run_end   = (emit_count == 6'd1) || (pixels_left == 32'd1);
  assign b         = in_data.data_byte;

  qoi_hdr_parser u_hdr (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .byte_en     (hdr_en),
    .data_byte   (b),
    .pixel_limit (pixel_limit),
    .hdr         (hdr)
  );

  // reads only start in S_INPUT and writes only happen in S_PIXEL, so a read
  // never overlaps a write and needs no forwarding
  qoi_color_table u_table (
    .clk     (clk),
    .rst     (rst),
    .clear   (restart),
    .rd_en   (pix_en && go_lookup),
    .rd_addr (b[5:0]),
    .rd_data (tbl_rd_data),
    .wr_en   (state == S_PIXEL),
    .wr_addr (qoi_pkg::qoi_hash(previous_pixel)),
    .wr_data (previous_pixel)
  );

  // op decode for a byte in the pixel phase
  always_comb begin
    pending_op_next    = pending_op;
    operand_count_next = operand_count;
    pixel_next         = previous_pixel;
    emit_n             = '0;
    go_lookup          = 1'b0;
    vg                 = pending_op[5:0] + 8'd224;
    k                  = ((pending_op == qoi_pkg::OP_RGBA) ? 2'd0 : 2'd3)
                       - operand_count[1:0];
    if (operand_count != '0) begin
      if (pending_op == qoi_pkg::OP_RGB || pending_op == qoi_pkg::OP_RGBA) begin
        case (k)
          2'd0:    pixel_next.r = b;
          2'd1:    pixel_next.g = b;
          2'd2:    pixel_next.b = b;
          default: pixel_next.a = b;
        endcase
      end else begin
        pixel_next.r = previous_pixel.r + vg + 8'd248 + {4'd0, b[7:4]};
        pixel_next.g = previous_pixel.g + vg;
        pixel_next.b = previous_pixel.b + vg + 8'd248 + {4'd0, b[3:0]};
      end
      operand_count_next = operand_count - 3'd1;
      if (operand_count == 3'd1) begin
        emit_n = 6'd1;
      end
    end else if (b == qoi_pkg::OP_RGB || b == qoi_pkg::OP_RGBA) begin
      pending_op_next    = b;
      operand_count_next = (b == qoi_pkg::OP_RGBA) ? 3'd4 : 3'd3;
    end else begin
      case (b[7:6])
        qoi_pkg::TAG_INDEX: go_lookup = 1'b1;
        qoi_pkg::TAG_DIFF: begin
          pixel_next.r = previous_pixel.r + {6'd0, b[5:4]} + 8'hFE;
          pixel_next.g = previous_pixel.g + {6'd0, b[3:2]} + 8'hFE;
          pixel_next.b = previous_pixel.b + {6'd0, b[1:0]} + 8'hFE;
          emit_n       = 6'd1;
        end
        qoi_pkg::TAG_LUMA: begin
          pending_op_next    = b;
          operand_count_next = 3'd1;
        end
        default: emit_n = b[5:0] + 6'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_INPUT;
      phase          <= PH_HEADER;
      pixel_limit    <= qoi_pkg::PIXEL_LIMIT_RESET;
      pending_op     <= '0;
      operand_count  <= '0;
      previous_pixel <= qoi_pkg::OPAQUE_BLACK;
      pixels_left    <= '0;
      emit_count     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        pixel_limit <= cfg_data;
      end
      if (ld_pix || ld_hdr) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INPUT: begin
          if (restart) begin
            phase          <= PH_HEADER;
            pending_op     <= '0;
            operand_count  <= '0;
            previous_pixel <= qoi_pkg::OPAQUE_BLACK;
            pixels_left    <= '0;
          end
          if (hdr.last) begin
            phase <= hdr.ok ? PH_PIXELS : PH_IDLE;
            if (hdr.ok) begin
              pixels_left <= hdr.pixel_count;
            end
            state <= S_HEADER;
          end
          if (pix_en) begin
            pending_op     <= pending_op_next;
            operand_count  <= operand_count_next;
            previous_pixel <= pixel_next;
            if (go_lookup) begin
              state <= S_LOOKUP;
            end else if (emit_n != '0) begin
              emit_count <= emit_n;
              state      <= S_PIXEL;
            end
          end
        end
        S_LOOKUP: begin
          previous_pixel <= tbl_rd_data;
          emit_count     <= 6'd1;
          state          <= S_PIXEL;
        end
        S_PIXEL: begin
          if (out_free) begin
            pixels_left <= pixels_left - 32'd1;
            emit_count  <= emit_count - 6'd1;
            if (run_end) begin
              state <= S_INPUT;
              if (pixels_left == 32'd1) begin
                phase <= PH_IDLE;
              end
            end
          end
        end
        S_HEADER: begin
          if (out_free) begin
            state <= S_INPUT;
          end
        end
        default: state <= S_INPUT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ld_pix) begin
      out_data               <= '0;
      out_data.kind          <= qoi_pkg::KIND_PIXEL;
      out_data.red           <= previous_pixel.r;
      out_data.green         <= previous_pixel.g;
      out_data.blue          <= previous_pixel.b;
      out_data.alpha         <= previous_pixel.a;
      out_data.run_last      <= run_end;
      out_data.image_last    <= (pixels_left == 32'd1);
    end else if (ld_hdr) begin
      out_data               <= '0;
      out_data.kind          <= (phase == PH_PIXELS) ? qoi_pkg::KIND_HDR_OK
                                                     : qoi_pkg::KIND_HDR_BAD;
      out_data.image_width   <= hdr.width;
      out_data.image_height  <= hdr.height;
      out_data.channel_count <= hdr.channels;
      out_data.color_space   <= hdr.colorspace;
    end
  end

  a_pixel_has_work : assert property (@(posedge clk) disable iff (rst)
    (state == S_PIXEL) |-> (emit_count != '0 && pixels_left != '0))
    else $error("pixel emission with nothing left to emit");

  a_pixel_in_phase : assert property (@(posedge clk) disable iff (rst)
    (state == S_PIXEL || state == S_LOOKUP) |-> (phase == PH_PIXELS))
    else $error("pixel work outside the pixel phase");

endmodule

`default_nettype wire
